[rtl/cache_way_replacement_unit_defines.svh]
// assertion macros for the cache way replacement unit
`ifndef CACHE_WAY_REPLACEMENT_UNIT_DEFINES_SVH
`define CACHE_WAY_REPLACEMENT_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CWR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define CWR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cwr_pkg.sv]
// package: payload types, codes and helpers of the cache way replacement unit
`default_nettype none

package cwr_pkg;

  localparam int WAY_W = 3;
  localparam int SET_W = 8;

  typedef struct packed {
    logic             command;
    logic [SET_W-1:0] set_index;
    logic [WAY_W-1:0] way;
  } in_t;

  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    logic             chosen_randomly;
  } out_t;

  localparam logic CMD_TOUCH  = 1'b0;
  localparam logic CMD_VICTIM = 1'b1;

  localparam logic [1:0] POL_DIRECT  = 2'd0;
  localparam logic [1:0] POL_ORDERED = 2'd1;
  localparam logic [1:0] POL_RANDOM  = 2'd2;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_WAYS   = 2'd1;
  localparam logic [1:0] REG_SEED   = 2'd2;

  localparam logic [1:0]  POLICY_RST = POL_ORDERED;
  localparam logic [3:0]  WAYS_RST   = 4'd8;
  localparam logic [31:0] SEED_RST   = 32'd1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_WRAP  = 7'b0000010,
    ST_FETCH = 7'b0000100,
    ST_SCAN  = 7'b0001000,
    ST_WRITE = 7'b0010000,
    ST_MOD   = 7'b0100000,
    ST_CLEAR = 7'b1000000
  } state_t;

  // xorshift32 with shifts 13, 17, 5
  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

`default_nettype wire

[rtl/cache_way_replacement_unit.sv]
// top level: per-set way ordering and victim selection with an iterative sequencer
//
// usage: start with in_data is taken when busy is low; a touch moves the way to the
// tail of its set's list and gives no result, a victim request gives one result on
// out_data, strobed by out_valid for exactly one cycle (the receiver cannot stall).
// configuration goes through the APB-style port at byte addresses 0, 4 and 8
// (policy, ways in use, seed); pready is always high.
// sequence: a touch or a list victim (ordered, or random on a non-empty list, which
// pops the head) runs one fetch, L scan steps of the shared compare/shift unit and
// one write-back, L being the set's list length; a random victim on an empty list
// runs the bit-serial modulo of 32 steps after the fetch; a direct-mapped victim
// (or unused policy code), an empty ordered list or a touch of an empty list returns
// to idle from the fetch. a set index at or above NUM_SETS first passes the wrap
// state, which subtracts NUM_SETS until it is below. the next transaction is taken
// once busy falls. reset, and every write of ways_in_use, clears all NUM_SETS sets,
// writing the ascending way order into each; busy stays high meanwhile.
`default_nettype none
`include "cache_way_replacement_unit_defines.svh"

module cache_way_replacement_unit #(
  parameter int NUM_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire cwr_pkg::in_t in_data,
  output logic              out_valid,
  output cwr_pkg::out_t     out_data,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  import cwr_pkg::*;

  localparam int LW = $clog2(MAX_WAYS + 1);
  localparam int IW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  typedef logic [MAX_WAYS-1:0][WAY_W-1:0] row_t;

  // set memories
  row_t          order_mem [NUM_SETS];
  logic [LW-1:0] len_mem   [NUM_SETS];
  row_t          rd_order_r;
  logic [LW-1:0] rd_len_r;

  state_t        state_r, state_nxt;
  logic [1:0]    policy_r, policy_nxt;
  logic [3:0]    ways_r, ways_nxt;
  logic [31:0]   seed_r, seed_nxt;
  logic [31:0]   rng_r, rng_nxt;
  logic [SW-1:0] clr_r, clr_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r, out_nxt;

  logic             cmd_r, cmd_nxt;
  logic [SET_W-1:0] set_r, set_nxt;
  logic [WAY_W-1:0] key_r, key_nxt;
  logic [WAY_W-1:0] vict_r, vict_nxt;
  logic             pop_r, pop_nxt;
  logic             found_r, found_nxt;
  logic [IW-1:0]    i_r, i_nxt;
  row_t             row_r, row_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic [31:0]      dv_r, dv_nxt;
  logic [LW-1:0]    rem_r, rem_nxt;
  logic [4:0]       cnt_r, cnt_nxt;

  logic          accept;
  logic          cfg_wr;
  logic [LW-1:0] assoc;
  row_t          init_row;
  logic [SET_W-1:0] set_sel;
  logic [SET_W-1:0] set_less;
  logic [SW-1:0] rd_addr;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  row_t          wr_order;
  logic [LW-1:0] wr_len;
  logic [IW-1:0] i_inc;
  logic [IW-1:0] tail_idx;
  logic          hit;
  logic          found_now;
  logic          scan_last;
  logic [LW:0]   rem_w;
  logic [LW:0]   rem_sub;
  logic [31:0]   rng_step;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    case (paddr[3:2])
      REG_POLICY: prdata = {30'd0, policy_r};
      REG_WAYS:   prdata = {28'd0, ways_r};
      REG_SEED:   prdata = seed_r;
      default:    prdata = 32'd0;
    endcase
  end

  // effective associativity: zero counts as one, clamp at MAX_WAYS
  always_comb begin
    if (ways_r == 4'd0) begin
      assoc = LW'(1);
    end else if (32'(ways_r) > MAX_WAYS) begin
      assoc = LW'(MAX_WAYS);
    end else begin
      assoc = LW'(ways_r);
    end
  end

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      init_row[w] = (w < 32'(assoc)) ? WAY_W'(w) : '0;
    end
  end

  // read address: incoming set, or the set after one more wrap subtraction
  assign set_less = set_r - SET_W'(NUM_SETS);
  assign set_sel  = (state_r == ST_WRAP) ? set_less : in_data.set_index;
  assign rd_addr  = SW'(set_sel);

  assign i_inc     = i_r + IW'(1);
  assign tail_idx  = IW'(len_r - LW'(1));
  assign hit       = (row_r[i_r] == key_r);
  assign found_now = found_r || hit;
  assign scan_last = ((32'(i_r) + 1) == 32'(len_r));

  assign rem_w    = {rem_r, dv_r[31]};
  assign rem_sub  = rem_w - {1'b0, assoc};
  assign rng_step = xorshift32(rng_r);

  always_comb begin
    wr_order = row_r;
    if (found_r && !pop_r) begin
      wr_order[tail_idx] = key_r;
    end
    wr_len = (found_r && pop_r) ? (len_r - LW'(1)) : len_r;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = SW'(set_r);
    if (state_r == ST_WRITE) begin
      wr_en = 1'b1;
    end else if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      order_mem[wr_addr] <= (state_r == ST_CLEAR) ? init_row : wr_order;
      len_mem[wr_addr]   <= (state_r == ST_CLEAR) ? assoc : wr_len;
    end
    rd_order_r <= order_mem[rd_addr];
    rd_len_r   <= len_mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    policy_nxt    = policy_r;
    ways_nxt      = ways_r;
    seed_nxt      = seed_r;
    rng_nxt       = rng_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    cmd_nxt       = cmd_r;
    set_nxt       = set_r;
    key_nxt       = key_r;
    vict_nxt      = vict_r;
    pop_nxt       = pop_r;
    found_nxt     = found_r;
    i_nxt         = i_r;
    row_nxt       = row_r;
    len_nxt       = len_r;
    dv_nxt        = dv_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt = in_data.command;
          set_nxt = in_data.set_index;
          key_nxt = in_data.way;
          state_nxt = (32'(in_data.set_index) < NUM_SETS) ? ST_FETCH : ST_WRAP;
        end
      end
      ST_WRAP: begin
        set_nxt = set_less;
        if (32'(set_less) < NUM_SETS) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        row_nxt   = rd_order_r;
        len_nxt   = rd_len_r;
        i_nxt     = '0;
        found_nxt = 1'b0;
        pop_nxt   = 1'b0;
        vict_nxt  = rd_order_r[0];
        if (cmd_r == CMD_TOUCH) begin
          state_nxt = (rd_len_r == '0) ? ST_IDLE : ST_SCAN;
        end else begin
          case (policy_r)
            POL_ORDERED: begin
              if (rd_len_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt       = '{victim_way: '0, chosen_randomly: 1'b0};
                state_nxt     = ST_IDLE;
              end else begin
                key_nxt   = rd_order_r[0];
                state_nxt = ST_SCAN;
              end
            end
            POL_RANDOM: begin
              if (rd_len_r != '0) begin
                key_nxt   = rd_order_r[0];
                pop_nxt   = 1'b1;
                state_nxt = ST_SCAN;
              end else begin
                rng_nxt   = rng_step;
                dv_nxt    = rng_step;
                rem_nxt   = '0;
                cnt_nxt   = '0;
                state_nxt = ST_MOD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{victim_way: '0, chosen_randomly: 1'b0};
              state_nxt     = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // one position per cycle: find the key, then pull later ways forward
        found_nxt = found_now;
        if (found_now && ((32'(i_r) + 1) < 32'(len_r))) begin
          row_nxt[i_r] = row_r[i_inc];
        end
        i_nxt = i_inc;
        if (scan_last) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (cmd_r == CMD_VICTIM) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{victim_way: vict_r, chosen_randomly: 1'b0};
        end
        state_nxt = ST_IDLE;
      end
      ST_MOD: begin
        // restoring remainder, one dividend bit per cycle
        rem_nxt = rem_sub[LW] ? LW'(rem_w) : LW'(rem_sub);
        dv_nxt  = {dv_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{victim_way: WAY_W'(rem_nxt), chosen_randomly: 1'b1};
          state_nxt     = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        clr_nxt = clr_r + SW'(1);
        if (clr_r == SW'(NUM_SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr) begin
      case (paddr[3:2])
        REG_POLICY: policy_nxt = pwdata[1:0];
        REG_WAYS: begin
          ways_nxt      = pwdata[3:0];
          clr_nxt       = '0;
          out_valid_nxt = 1'b0;
          state_nxt     = ST_CLEAR;
        end
        REG_SEED: begin
          seed_nxt = pwdata;
          rng_nxt  = (pwdata == 32'd0) ? 32'd1 : pwdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      policy_r    <= POLICY_RST;
      ways_r      <= WAYS_RST;
      seed_r      <= SEED_RST;
      rng_r       <= SEED_RST;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      policy_r    <= policy_nxt;
      ways_r      <= ways_nxt;
      seed_r      <= seed_nxt;
      rng_r       <= rng_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    cmd_r   <= cmd_nxt;
    set_r   <= set_nxt;
    key_r   <= key_nxt;
    vict_r  <= vict_nxt;
    pop_r   <= pop_nxt;
    found_r <= found_nxt;
    i_r     <= i_nxt;
    row_r   <= row_nxt;
    len_r   <= len_nxt;
    dv_r    <= dv_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
  end

  `CWR_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `CWR_ASSERT_NXT(a_single_strobe, out_valid, !out_valid, "result strobe lasted two cycles")
  `CWR_ASSERT_IMP(a_scan_bound, state_r == ST_SCAN, 32'(i_r) < 32'(len_r), "scan ran past list")

endmodule

`default_nettype wire

[test/replacement_monitor.sv]
// checker: tracks per-set way order, predicts victims and compares every result
module replacement_monitor #(
  parameter int NUM_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  cwr_pkg::in_t   in_data,
  input  logic           out_valid,
  input  cwr_pkg::out_t  out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic           pready,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output int             fail_count,
  output int             victims_checked,
  output int             n_pending
);
  import cwr_pkg::*;

  logic [2:0]    order_tab [NUM_SETS][MAX_WAYS];
  logic [3:0]    len_tab [NUM_SETS];
  logic [31:0]   rng;
  logic [1:0]    policy_reg;
  logic [3:0]    ways_reg;
  out_t          victims_due [$];

  // associativity with 0 read as 1 and the top clamped
  function automatic int span();
    if (ways_reg == 4'd0) return 1;
    if (ways_reg > MAX_WAYS) return MAX_WAYS;
    return int'(ways_reg);
  endfunction

  task automatic rebuild_lists();
    int n;
    n = span();
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < MAX_WAYS; w++)
        order_tab[s][w] = (w < n) ? w[2:0] : 3'd0;
      len_tab[s] = n[3:0];
    end
  endtask

  // move a way to the most-recent end if it is in the list and not already last
  task automatic to_tail(input int s, input logic [2:0] w);
    int len;
    int pos;
    len = int'(len_tab[s]);
    pos = len;
    if (len == 0) return;
    if (order_tab[s][len-1] == w) return;
    for (int i = 0; i < len; i++)
      if (order_tab[s][i] == w && pos == len) pos = i;
    if (pos == len) return;
    for (int i = pos; i + 1 < len; i++)
      order_tab[s][i] = order_tab[s][i+1];
    order_tab[s][len-1] = w;
  endtask

  task automatic predict_victim(input int s, output out_t res);
    int len;
    logic [31:0] x;
    len = int'(len_tab[s]);
    res = '0;
    case (policy_reg)
      POL_ORDERED: begin
        if (len != 0) begin
          res.victim_way = order_tab[s][0];
          to_tail(s, order_tab[s][0]);
        end
      end
      POL_RANDOM: begin
        if (len != 0) begin
          // pop the way at the head off the list
          res.victim_way = order_tab[s][0];
          for (int i = 0; i + 1 < len; i++)
            order_tab[s][i] = order_tab[s][i+1];
          len_tab[s] = 4'(len - 1);
        end else begin
          x = rng;
          x = x ^ (x << 13);
          x = x ^ (x >> 17);
          x = x ^ (x << 5);
          rng = x;
          res.victim_way = 3'(x % span());
          res.chosen_randomly = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    out_t want;
    int s;
    if (!rst_n) begin
      policy_reg = POLICY_RST;
      ways_reg = WAYS_RST;
      rng = SEED_RST;
      rebuild_lists();
      victims_due.delete();
      fail_count = 0;
      victims_checked = 0;
      n_pending <= 0;
    end else begin
      // results are retired before a new transaction is predicted
      if (out_valid) begin
        if (victims_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: way %0d rnd %0b",
                                    out_data.victim_way, out_data.chosen_randomly));
        end else begin
          want = victims_due.pop_front();
          if (out_data.victim_way !== want.victim_way)
            report_mismatch($sformatf("victim_way got %0d want %0d",
                                      out_data.victim_way, want.victim_way));
          if (out_data.chosen_randomly !== want.chosen_randomly)
            report_mismatch($sformatf("chosen_randomly got %0b want %0b",
                                      out_data.chosen_randomly, want.chosen_randomly));
        end
        victims_checked++;
      end
      if (start && !busy) begin
        s = int'(in_data.set_index) % NUM_SETS;
        if (in_data.command == CMD_VICTIM) begin
          predict_victim(s, want);
          victims_due.push_back(want);
        end else begin
          to_tail(s, in_data.way);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_POLICY: policy_reg = pwdata[1:0];
          REG_WAYS: begin
            ways_reg = pwdata[3:0];
            rebuild_lists();
          end
          REG_SEED: rng = (pwdata == 32'd0) ? 32'd1 : pwdata;
          default: ;
        endcase
      end
      n_pending <= victims_due.size();
    end
  end

endmodule

[test/tb_top.sv]
// testbench top: drives touch and victim transactions plus register writes
module tb_top;
  import cwr_pkg::*;

  localparam logic [1:0] POL_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 48;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_PHASES = 10;
  localparam int PHASE_ITEMS = 150;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  in_t           in_data = '0;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [3:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic          busy;
  logic          out_valid;
  out_t          out_data;
  logic [31:0]   prdata;
  logic          pready;

  int            fail_count;
  int            victims_checked;
  int            n_pending;
  int            idle_cycles = 0;
  int            burst_left = 0;
  int            n_items = 0;
  int            n_writes = 0;
  logic [7:0]    set_pool [4];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cache_way_replacement_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  replacement_monitor mon (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_data        (out_data),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .victims_checked (victims_checked),
    .n_pending       (n_pending)
  );

  // watchdog: cycles with no accepted transaction, no result and no register write
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (psel && penable && pwrite)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("cache_way_replacement_unit test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // start stays high across back-to-back transactions within a burst
  task automatic issue(input logic cmd, input logic [7:0] s, input logic [2:0] w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_data <= in_t'{command: cmd, set_index: s, way: w};
    do @(posedge clk); while (busy);
    n_items++;
  endtask

  task automatic settle();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    // touches give no result, so let the last one finish
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    n_writes++;
    // a ways write kicks off a clearing pass
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic random_item();
    logic [7:0] s;
    logic cmd;
    s = ($urandom_range(0, 4) != 0) ? set_pool[$urandom_range(0, 3)] : 8'($urandom);
    cmd = ($urandom_range(0, 99) < 45) ? CMD_VICTIM : CMD_TOUCH;
    issue(cmd, s, 3'($urandom));
  endtask

  initial begin
    int r;
    logic [1:0] pol;
    logic [3:0] ways;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ordered list from reset
    issue(CMD_TOUCH, 8'd0, 3'd7);
    issue(CMD_TOUCH, 8'd0, 3'd0);
    issue(CMD_VICTIM, 8'd0, 3'd0);
    issue(CMD_VICTIM, 8'd255, 3'd7);
    issue(CMD_TOUCH, 8'd255, 3'd3);
    issue(CMD_VICTIM, 8'd255, 3'd0);
    settle();
    write_reg(REG_POLICY, {30'd0, POL_DIRECT});
    issue(CMD_VICTIM, 8'd9, 3'd7);
    settle();
    write_reg(REG_POLICY, {30'd0, POL_UNUSED});
    issue(CMD_VICTIM, 8'd255, 3'd0);
    // random policy: single way, zero seed
    settle();
    write_reg(REG_POLICY, {30'd0, POL_RANDOM});
    write_reg(REG_WAYS, 32'd1);
    write_reg(REG_SEED, 32'd0);
    issue(CMD_VICTIM, 8'd7, 3'd0);
    issue(CMD_TOUCH, 8'd7, 3'd0);
    issue(CMD_VICTIM, 8'd7, 3'd0);
    settle();
    write_reg(REG_WAYS, 32'd2);
    issue(CMD_TOUCH, 8'd0, 3'd5);
    issue(CMD_TOUCH, 8'd0, 3'd0);
    issue(CMD_VICTIM, 8'd0, 3'd0);
    issue(CMD_TOUCH, 8'd0, 3'd1);
    issue(CMD_VICTIM, 8'd0, 3'd0);
    issue(CMD_VICTIM, 8'd0, 3'd0);
    // ordered victim on a drained list
    settle();
    write_reg(REG_POLICY, {30'd0, POL_ORDERED});
    issue(CMD_VICTIM, 8'd0, 3'd0);
    settle();
    write_reg(REG_POLICY, {30'd0, POL_RANDOM});
    write_reg(REG_WAYS, 32'd0);
    write_reg(REG_SEED, 32'hFFFF_FFFF);
    issue(CMD_VICTIM, 8'd3, 3'd0);
    issue(CMD_VICTIM, 8'd3, 3'd0);
    issue(CMD_VICTIM, 8'd3, 3'd0);
    settle();
    write_reg(REG_WAYS, 32'd15);
    issue(CMD_TOUCH, 8'd200, 3'd7);
    issue(CMD_VICTIM, 8'd200, 3'd0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      r = $urandom_range(0, 9);
      pol = (r == 0) ? POL_DIRECT : (r == 1) ? POL_UNUSED : (r < 6) ? POL_ORDERED : POL_RANDOM;
      write_reg(REG_POLICY, {30'd0, pol});
      if ($urandom_range(0, 2) != 0) begin
        ways = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        write_reg(REG_WAYS, {28'd0, ways});
      end
      if ($urandom_range(0, 1) != 0)
        write_reg(REG_SEED, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom);
      // a few hot sets so lists drain and the generator gets used
      for (int i = 0; i < 4; i++) set_pool[i] = 8'($urandom);
      repeat (PHASE_ITEMS) random_item();
    end

    settle();
    $display("covered %0d transactions and %0d register writes over %0d random phases",
             n_items, n_writes, N_PHASES);
    $display("%0d victim results compared, %0d mismatches", victims_checked, fail_count);
    if (fail_count == 0) begin
      $display("cache_way_replacement_unit test passed");
    end else begin
      $display("cache_way_replacement_unit test failed");
    end
    $finish;
  end

endmodule
